[sv/sm83_load_instruction_unit_top_macros.svh]
// Assertion shorthands shared by the RTL; clock and reset come from the using module.
`ifndef SM83_LOAD_INSTRUCTION_UNIT_TOP_MACROS_SVH
`define SM83_LOAD_INSTRUCTION_UNIT_TOP_MACROS_SVH

// Same-cycle implication.
`define SM83LI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SM83LI_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/sm83li_pkg.sv]
`default_nettype none

package sm83li_pkg;

   localparam int unsigned ADDR_BITS_DFLT = 16;

   localparam logic [7:0]  HIGH_PAGE = 8'hFF;
   localparam logic [15:0] PC_RESET  = 16'h0100;
   localparam logic [7:0]  A_RESET   = 8'h01;
   localparam logic [7:0]  B_RESET   = 8'hFF;
   localparam logic [7:0]  C_RESET   = 8'h13;
   localparam logic [7:0]  D_RESET   = 8'h00;
   localparam logic [7:0]  E_RESET   = 8'hC1;
   localparam logic [7:0]  H_RESET   = 8'h84;
   localparam logic [7:0]  L_RESET   = 8'h03;

   typedef logic [2:0] reg_code_type;

   localparam reg_code_type REG_B      = 3'd0;
   localparam reg_code_type REG_C      = 3'd1;
   localparam reg_code_type REG_D      = 3'd2;
   localparam reg_code_type REG_E      = 3'd3;
   localparam reg_code_type REG_H      = 3'd4;
   localparam reg_code_type REG_L      = 3'd5;
   localparam reg_code_type REG_MEM_HL = 3'd6;
   localparam reg_code_type REG_A      = 3'd7;

   // opcode groups by the top two bits
   localparam logic [1:0] OPG_LOW  = 2'b00;
   localparam logic [1:0] OPG_MOVE = 2'b01;

   localparam logic [7:0] OP_HALT     = 8'h76;
   localparam logic [7:0] OP_LD_BC_A  = 8'h02;
   localparam logic [7:0] OP_LD_DE_A  = 8'h12;
   localparam logic [7:0] OP_LD_A_BC  = 8'h0A;
   localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
   localparam logic [7:0] OP_LD_A_NN  = 8'hFA;
   localparam logic [7:0] OP_LDH_A_C  = 8'hF2;
   localparam logic [7:0] OP_LDH_C_A  = 8'hE2;
   localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
   localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
   localparam logic [7:0] OP_LD_A_HLI = 8'h2A;
   localparam logic [7:0] OP_LD_HLI_A = 8'h22;
   localparam logic [7:0] OP_LD_A_HLD = 8'h3A;
   localparam logic [7:0] OP_LD_HLD_A = 8'h32;

   typedef enum logic [2:0] {
      ASEL_HL, ASEL_BC, ASEL_DE, ASEL_NN, ASEL_HIGH_C, ASEL_HIGH_N
   } addr_sel_type;

   typedef enum logic [1:0] {DSRC_REG, DSRC_IMM, DSRC_MEM} data_src_type;

   typedef enum logic [1:0] {HL_KEEP, HL_INC, HL_DEC} hl_step_type;

   typedef struct packed {
      logic         illegal;
      logic [1:0]   len;
      logic         store;
      logic         wr_reg;
      reg_code_type dst;
      reg_code_type src;
      data_src_type dsrc;
      addr_sel_type asel;
      hl_step_type  hl_step;
   } decode_type;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
      logic [7:0] d;
      logic [7:0] e;
      logic [7:0] h;
      logic [7:0] l;
   } regs_type;

   typedef struct packed {
      logic [7:0] func;
      logic [7:0] imm_lo;
      logic [7:0] imm_hi;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_a;
      logic [7:0]  out_b;
      logic [7:0]  out_c;
      logic [7:0]  out_d;
      logic [7:0]  out_e;
      logic [7:0]  out_h;
      logic [7:0]  out_l;
      logic [15:0] next_pc;
      logic        store_valid;
      logic [15:0] store_addr;
      logic [7:0]  store_data;
      logic        illegal_op;
   } rsp_payload_type;

   function automatic decode_type decode(input logic [7:0] op);
      decode_type d;
      d = '{illegal: 1'b1, len: 2'd1, store: 1'b0, wr_reg: 1'b0, dst: REG_A, src: REG_A,
            dsrc: DSRC_REG, asel: ASEL_HL, hl_step: HL_KEEP};
      if (op[7:6] == OPG_MOVE) begin
         if (op != OP_HALT) begin
            d.illegal = 1'b0;
            d.dst     = op[5:3];
            d.src     = op[2:0];
            if (op[5:3] == REG_MEM_HL) begin
               d.store = 1'b1;
            end else if (op[2:0] == REG_MEM_HL) begin
               d.wr_reg = 1'b1;
               d.dsrc   = DSRC_MEM;
            end else begin
               d.wr_reg = 1'b1;
            end
         end
      end else if (op[7:6] == OPG_LOW && op[2:0] == REG_MEM_HL) begin
         d.illegal = 1'b0;
         d.len     = 2'd2;
         d.dsrc    = DSRC_IMM;
         d.dst     = op[5:3];
         if (op[5:3] == REG_MEM_HL) begin
            d.store = 1'b1;
         end else begin
            d.wr_reg = 1'b1;
         end
      end else begin
         unique case (op)
            OP_LD_A_BC: begin
               d.illegal = 1'b0; d.wr_reg = 1'b1; d.dsrc = DSRC_MEM; d.asel = ASEL_BC;
            end
            OP_LD_A_DE: begin
               d.illegal = 1'b0; d.wr_reg = 1'b1; d.dsrc = DSRC_MEM; d.asel = ASEL_DE;
            end
            OP_LD_A_NN: begin
               d.illegal = 1'b0; d.wr_reg = 1'b1; d.dsrc = DSRC_MEM; d.asel = ASEL_NN;
               d.len = 2'd3;
            end
            OP_LDH_A_C: begin
               d.illegal = 1'b0; d.wr_reg = 1'b1; d.dsrc = DSRC_MEM; d.asel = ASEL_HIGH_C;
            end
            OP_LDH_A_N: begin
               d.illegal = 1'b0; d.wr_reg = 1'b1; d.dsrc = DSRC_MEM; d.asel = ASEL_HIGH_N;
               d.len = 2'd2;
            end
            OP_LD_A_HLI: begin
               d.illegal = 1'b0; d.wr_reg = 1'b1; d.dsrc = DSRC_MEM; d.hl_step = HL_INC;
            end
            OP_LD_A_HLD: begin
               d.illegal = 1'b0; d.wr_reg = 1'b1; d.dsrc = DSRC_MEM; d.hl_step = HL_DEC;
            end
            OP_LD_BC_A: begin
               d.illegal = 1'b0; d.store = 1'b1; d.asel = ASEL_BC;
            end
            OP_LD_DE_A: begin
               d.illegal = 1'b0; d.store = 1'b1; d.asel = ASEL_DE;
            end
            OP_LDH_C_A: begin
               d.illegal = 1'b0; d.store = 1'b1; d.asel = ASEL_HIGH_C;
            end
            OP_LDH_N_A: begin
               d.illegal = 1'b0; d.store = 1'b1; d.asel = ASEL_HIGH_N; d.len = 2'd2;
            end
            OP_LD_HLI_A: begin
               d.illegal = 1'b0; d.store = 1'b1; d.hl_step = HL_INC;
            end
            OP_LD_HLD_A: begin
               d.illegal = 1'b0; d.store = 1'b1; d.hl_step = HL_DEC;
            end
            default: begin
               d.illegal = 1'b1;
            end
         endcase
      end
      return d;
   endfunction

   function automatic logic [7:0] reg_get(input regs_type r, input reg_code_type code);
      logic [7:0] v;
      case (code)
         REG_B:   v = r.b;
         REG_C:   v = r.c;
         REG_D:   v = r.d;
         REG_E:   v = r.e;
         REG_H:   v = r.h;
         REG_L:   v = r.l;
         REG_A:   v = r.a;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic regs_type reg_set(input regs_type r, input reg_code_type code,
                                        input logic [7:0] v);
      regs_type q;
      q = r;
      case (code)
         REG_B:   q.b = v;
         REG_C:   q.c = v;
         REG_D:   q.d = v;
         REG_E:   q.e = v;
         REG_H:   q.h = v;
         REG_L:   q.l = v;
         REG_A:   q.a = v;
         default: q = r;
      endcase
      return q;
   endfunction

   function automatic logic [15:0] mem_addr(input addr_sel_type asel, input regs_type r,
                                            input logic [7:0] lo, input logic [7:0] hi);
      logic [15:0] a;
      unique case (asel)
         ASEL_HL:     a = {r.h, r.l};
         ASEL_BC:     a = {r.b, r.c};
         ASEL_DE:     a = {r.d, r.e};
         ASEL_NN:     a = {hi, lo};
         ASEL_HIGH_C: a = {HIGH_PAGE, r.c};
         ASEL_HIGH_N: a = {HIGH_PAGE, lo};
         default:     a = {r.h, r.l};
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

[sv/sm83li_chan_if.sv]
`default_nettype none

interface sm83li_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/sm83li_dmem.sv]
`default_nettype none

// Byte-wide data memory, one read and one write port, registered read.
// Clears itself after reset; a write landing on the address read in the
// same cycle is bypassed into the read data.
module sm83li_dmem import sm83li_pkg::*; #(
   parameter int unsigned ADDR_BITS = ADDR_BITS_DFLT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [7:0]           rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]           wr_data,
   output logic                 busy
);

   localparam int unsigned DEPTH = 1 << ADDR_BITS;

   logic [7:0]           mem_q [DEPTH];
   logic                 clr_busy_ff, clr_busy_in;
   logic [ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [7:0]           rd_q_ff;
   logic                 byp_hit_ff;
   logic [7:0]           byp_data_ff;
   logic                 we;
   logic [ADDR_BITS-1:0] wa;
   logic [7:0]           wd;

   assign we = clr_busy_ff || wr_en;
   assign wa = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign wd = clr_busy_ff ? 8'h00 : wr_data;

   assign clr_busy_in = clr_busy_ff && (clr_addr_ff != {ADDR_BITS{1'b1}});
   assign clr_addr_in = clr_addr_ff + {{(ADDR_BITS-1){1'b0}}, 1'b1};

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // read-first: a same-cycle write shows up through the bypass
   always_ff @(posedge clock) begin
      if (we) begin
         mem_q[wa] <= wd;
      end
      if (rd_en) begin
         rd_q_ff <= mem_q[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_hit_ff  <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : rd_q_ff;
   assign busy    = clr_busy_ff;

endmodule

`default_nettype wire

[sv/sm83_load_instruction_unit_top.sv]
`default_nettype none

// Channel   Port       Dir  Payload
// --------  ---------  ---  -------------------------------------------------
// request   req_chan   in   func, imm_lo, imm_hi (one instruction per beat)
// response  rsp_chan   out  A..L, next_pc, store fields, illegal_op per beat
//
// Cycles: one instruction per clock sustained while rsp_chan.ready stays high; a request
//   beat starts its memory read as it is taken into the execute stage, then executes
//   into the output register, from which its response beat is taken.
// Reset: synchronous; registers and PC load, then the memory is swept to zero, all
//   2**ADDR_BITS bytes (65536 by default), with req_chan.ready low.
// Stalls: execute holds while the output register is full and not taken.

`include "sm83_load_instruction_unit_top_macros.svh"

module sm83_load_instruction_unit_top import sm83li_pkg::*; #(
   parameter int unsigned ADDR_BITS = ADDR_BITS_DFLT
) (
   input  logic          clock,
   input  logic          reset,
   sm83li_chan_if.sink   req_chan,
   sm83li_chan_if.source rsp_chan
);

   // architectural state
   regs_type        regs_ff, regs_in;
   logic [15:0]     pc_ff, pc_in;

   // execute stage
   logic            s2_valid_ff, s2_valid_in;
   decode_type      s2_dec_ff;
   logic [7:0]      s2_imm_ff;
   logic [15:0]     s2_addr_ff;

   // output register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff;

   logic            s2_adv;
   logic            req_take;
   decode_type      in_dec;
   regs_type        fwd_regs;
   logic [15:0]     in_addr;
   logic [7:0]      mem_rdata;
   logic            mem_busy;
   logic [7:0]      s2_val;
   regs_type        s2_regs_w, s2_regs;
   logic [15:0]     s2_hl, s2_hl_new;
   rsp_payload_type s2_rsp;

   // Handshake: advance execute when the output register is free or being
   // drained; take a request beat only when execute can make room and memory is not clearing.
   assign s2_adv         = s2_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !mem_busy && (!s2_valid_ff || s2_adv);
   assign req_take       = req_chan.valid && req_chan.ready;

   // Execute: the operand byte comes from memory, the immediate or a register.
   always_comb begin
      case (s2_dec_ff.dsrc)
         DSRC_MEM: s2_val = mem_rdata;
         DSRC_IMM: s2_val = s2_imm_ff;
         default:  s2_val = reg_get(regs_ff, s2_dec_ff.src);
      endcase
   end

   always_comb begin
      s2_regs_w = s2_dec_ff.wr_reg ? reg_set(regs_ff, s2_dec_ff.dst, s2_val) : regs_ff;
      s2_hl     = {regs_ff.h, regs_ff.l};
      case (s2_dec_ff.hl_step)
         HL_INC:  s2_hl_new = s2_hl + 16'd1;
         HL_DEC:  s2_hl_new = s2_hl - 16'd1;
         default: s2_hl_new = s2_hl;
      endcase
      s2_regs = s2_regs_w;
      // HL stepping only pairs with A as the register target, so no clash
      if (s2_dec_ff.hl_step != HL_KEEP) begin
         s2_regs.h = s2_hl_new[15:8];
         s2_regs.l = s2_hl_new[7:0];
      end
   end

   assign pc_in     = pc_ff + 16'(s2_dec_ff.len);
   assign regs_in   = s2_regs;

   always_comb begin
      s2_rsp.out_a       = s2_regs.a;
      s2_rsp.out_b       = s2_regs.b;
      s2_rsp.out_c       = s2_regs.c;
      s2_rsp.out_d       = s2_regs.d;
      s2_rsp.out_e       = s2_regs.e;
      s2_rsp.out_h       = s2_regs.h;
      s2_rsp.out_l       = s2_regs.l;
      s2_rsp.next_pc     = pc_in;
      s2_rsp.store_valid = s2_dec_ff.store;
      s2_rsp.store_addr  = s2_dec_ff.store ? s2_addr_ff : 16'h0000;
      s2_rsp.store_data  = s2_dec_ff.store ? s2_val : 8'h00;
      s2_rsp.illegal_op  = s2_dec_ff.illegal;
   end

   // Issue: the address uses the registers as they will stand after the
   // instruction in execute, so back-to-back dependences need no bubble.
   assign fwd_regs = s2_valid_ff ? s2_regs : regs_ff;
   assign in_dec   = decode(req_chan.data.func);
   assign in_addr  = mem_addr(in_dec.asel, fwd_regs, req_chan.data.imm_lo,
                              req_chan.data.imm_hi);

   assign s2_valid_in  = req_take ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
   assign out_valid_in = s2_adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   sm83li_dmem #(
      .ADDR_BITS (ADDR_BITS)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (in_addr[ADDR_BITS-1:0]),
      .rd_data (mem_rdata),
      .wr_en   (s2_adv && s2_dec_ff.store),
      .wr_addr (s2_addr_ff[ADDR_BITS-1:0]),
      .wr_data (s2_val),
      .busy    (mem_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff      <= '{a: A_RESET, b: B_RESET, c: C_RESET, d: D_RESET,
                           e: E_RESET, h: H_RESET, l: L_RESET};
         pc_ff        <= PC_RESET;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         // commit the instruction as it leaves execute
         if (s2_adv) begin
            regs_ff <= regs_in;
            pc_ff   <= pc_in;
         end
      end
   end

   // payload: hold unless a new beat loads it
   always_ff @(posedge clock) begin
      if (req_take) begin
         s2_dec_ff  <= in_dec;
         s2_imm_ff  <= req_chan.data.imm_lo;
         s2_addr_ff <= in_addr;
      end
      if (s2_adv) begin
         out_data_ff <= s2_rsp;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   `SM83LI_ASSERT_NOW(a_no_take_clear, mem_busy, !req_chan.ready, "request taken during clear")
   `SM83LI_ASSERT_NXT(a_s2_hold, s2_valid_ff && !s2_adv,
      s2_valid_ff && $stable(s2_addr_ff), "execute stage lost a stalled instruction")
   `SM83LI_ASSERT_NXT(a_rsp_load, s2_adv, rsp_chan.valid, "retired instruction gave no beat")
   `SM83LI_ASSERT_NOW(a_illegal_no_store, rsp_chan.valid && rsp_chan.data.illegal_op,
      !rsp_chan.data.store_valid, "illegal opcode reported a store")
   `SM83LI_ASSERT_NOW(a_nostore_zero, rsp_chan.valid && !rsp_chan.data.store_valid,
      rsp_chan.data.store_addr == 16'h0000 && rsp_chan.data.store_data == 8'h00,
      "store fields not cleared without a store")

endmodule

`default_nettype wire

[test/sm83_load_instruction_unit_top_test.sv]
`default_nettype none

module sm83_load_instruction_unit_top_test import sm83li_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ADDR_BITS    = ADDR_BITS_DFLT;
   localparam logic [15:0] ADDR_MASK    = 16'((17'd1 << ADDR_BITS) - 17'd1);
   localparam int          RANDOM_BEATS = 1700;
   localparam int          QUIET_TAIL   = 200;

   // Opcodes outside the load subset, used to hit the unsupported path by name.
   localparam logic [7:0] OP_NOP      = 8'h00;
   localparam logic [7:0] OP_LD_NN_A  = 8'hEA;
   localparam logic [7:0] OP_RST_38   = 8'hFF;

   // Shadow of the architectural state: registers, PC and the byte memory.
   // Each accepted instruction beat is executed here at once and the
   // resulting writeback is queued until the matching response beat shows up.
   class load_unit_shadow;
      regs_type        regs;
      logic [15:0]     pc;
      bit [7:0]        mem [0:65535];
      rsp_payload_type writeback_q [$];
      int unsigned     errors;
      int unsigned     checked;
      int unsigned     stores;
      int unsigned     illegals;

      function new();
         regs = '{a: A_RESET, b: B_RESET, c: C_RESET, d: D_RESET,
                  e: E_RESET, h: H_RESET, l: L_RESET};
         pc = PC_RESET;
      endfunction

      function logic [7:0] read_reg(reg_code_type code);
         case (code)
            REG_B:   return regs.b;
            REG_C:   return regs.c;
            REG_D:   return regs.d;
            REG_E:   return regs.e;
            REG_H:   return regs.h;
            REG_L:   return regs.l;
            REG_A:   return regs.a;
            default: return 8'h00;
         endcase
      endfunction

      function void write_reg(reg_code_type code, logic [7:0] v);
         case (code)
            REG_B:   regs.b = v;
            REG_C:   regs.c = v;
            REG_D:   regs.d = v;
            REG_E:   regs.e = v;
            REG_H:   regs.h = v;
            REG_L:   regs.l = v;
            REG_A:   regs.a = v;
            default: ;
         endcase
      endfunction

      function logic [7:0] load_byte(logic [15:0] addr);
         return mem[addr & ADDR_MASK];
      endfunction

      function rsp_payload_type execute_load(req_payload_type ins);
         rsp_payload_type wb;
         logic [15:0]     hl;
         logic [1:0]      len;
         logic            st;
         logic [15:0]     sa;
         logic [7:0]      sd;
         reg_code_type    dst;
         reg_code_type    src;
         wb  = '0;
         hl  = {regs.h, regs.l};
         len = 2'd1;
         st  = 1'b0;
         sa  = 16'h0000;
         sd  = 8'h00;
         dst = ins.func[5:3];
         src = ins.func[2:0];
         if (ins.func[7:6] == OPG_MOVE) begin
            if (ins.func == OP_HALT) begin
               wb.illegal_op = 1'b1;
            end else if (dst == REG_MEM_HL) begin
               st = 1'b1; sa = hl; sd = read_reg(src);
            end else if (src == REG_MEM_HL) begin
               write_reg(dst, load_byte(hl));
            end else begin
               write_reg(dst, read_reg(src));
            end
         end else if (ins.func[7:6] == OPG_LOW && src == REG_MEM_HL) begin
            len = 2'd2;
            if (dst == REG_MEM_HL) begin
               st = 1'b1; sa = hl; sd = ins.imm_lo;
            end else begin
               write_reg(dst, ins.imm_lo);
            end
         end else begin
            case (ins.func)
               OP_LD_A_BC:  regs.a = load_byte({regs.b, regs.c});
               OP_LD_A_DE:  regs.a = load_byte({regs.d, regs.e});
               OP_LD_BC_A:  begin st = 1'b1; sa = {regs.b, regs.c}; sd = regs.a; end
               OP_LD_DE_A:  begin st = 1'b1; sa = {regs.d, regs.e}; sd = regs.a; end
               OP_LD_A_NN:  begin len = 2'd3; regs.a = load_byte({ins.imm_hi, ins.imm_lo}); end
               OP_LDH_A_C:  regs.a = load_byte({HIGH_PAGE, regs.c});
               OP_LDH_C_A:  begin st = 1'b1; sa = {HIGH_PAGE, regs.c}; sd = regs.a; end
               OP_LDH_A_N:  begin len = 2'd2; regs.a = load_byte({HIGH_PAGE, ins.imm_lo}); end
               OP_LDH_N_A:  begin
                  len = 2'd2; st = 1'b1; sa = {HIGH_PAGE, ins.imm_lo}; sd = regs.a;
               end
               OP_LD_A_HLI: begin regs.a = load_byte(hl); {regs.h, regs.l} = hl + 16'd1; end
               OP_LD_A_HLD: begin regs.a = load_byte(hl); {regs.h, regs.l} = hl - 16'd1; end
               OP_LD_HLI_A: begin
                  st = 1'b1; sa = hl; sd = regs.a; {regs.h, regs.l} = hl + 16'd1;
               end
               OP_LD_HLD_A: begin
                  st = 1'b1; sa = hl; sd = regs.a; {regs.h, regs.l} = hl - 16'd1;
               end
               default:     wb.illegal_op = 1'b1;
            endcase
         end
         if (st) begin
            mem[sa & ADDR_MASK] = sd;
            stores++;
         end
         if (wb.illegal_op) illegals++;
         pc = pc + 16'(len);
         wb.out_a       = regs.a;
         wb.out_b       = regs.b;
         wb.out_c       = regs.c;
         wb.out_d       = regs.d;
         wb.out_e       = regs.e;
         wb.out_h       = regs.h;
         wb.out_l       = regs.l;
         wb.next_pc     = pc;
         wb.store_valid = st;
         wb.store_addr  = sa;
         wb.store_data  = sd;
         return wb;
      endfunction

      function void note_instruction(req_payload_type ins);
         writeback_q.push_back(execute_load(ins));
      endfunction

      function int pending();
         return writeback_q.size();
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         end
      endfunction

      function void check_writeback(rsp_payload_type got);
         rsp_payload_type want;
         if (writeback_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("%0t: response beat with no instruction pending", $time);
            return;
         end
         want = writeback_q.pop_front();
         checked++;
         compare_field("out_a",       16'(want.out_a),       16'(got.out_a));
         compare_field("out_b",       16'(want.out_b),       16'(got.out_b));
         compare_field("out_c",       16'(want.out_c),       16'(got.out_c));
         compare_field("out_d",       16'(want.out_d),       16'(got.out_d));
         compare_field("out_e",       16'(want.out_e),       16'(got.out_e));
         compare_field("out_h",       16'(want.out_h),       16'(got.out_h));
         compare_field("out_l",       16'(want.out_l),       16'(got.out_l));
         compare_field("next_pc",     want.next_pc,          got.next_pc);
         compare_field("store_valid", 16'(want.store_valid), 16'(got.store_valid));
         compare_field("store_addr",  want.store_addr,       got.store_addr);
         compare_field("store_data",  16'(want.store_data),  16'(got.store_data));
         compare_field("illegal_op",  16'(want.illegal_op),  16'(got.illegal_op));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   // 0: no idling on either side, 1 and 2: increasingly bursty traffic.
   int unsigned busy_level = 0;
   int unsigned directed_beats = 0;

   load_unit_shadow shadow = new();

   sm83li_chan_if #(.payload_type(req_payload_type)) req_chan ();
   sm83li_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   sm83_load_instruction_unit_top #(.ADDR_BITS(ADDR_BITS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watch both channels at every rising edge. Check the response side first
   // so that a beat never meets an expectation queued at the very same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) shadow.check_writeback(rsp_chan.data);
         if (req_chan.valid && req_chan.ready) shadow.note_instruction(req_chan.data);
      end
   end

   // Drive the response ready: random stall bursts while traffic is busy,
   // otherwise hold ready high.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (busy_level != 0 && $urandom_range(0, 3) < busy_level) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // Hard stop; covers the memory sweep after reset plus a very slow run many times over.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [7:0] ld_imm(reg_code_type r);
      return {OPG_LOW, r, REG_MEM_HL};
   endfunction

   function automatic logic [7:0] ld_move(reg_code_type d, reg_code_type s);
      return {OPG_MOVE, d, s};
   endfunction

   // Mostly draw from a small pool so that register pairs and nn land on a
   // handful of addresses and loads read back what earlier stores wrote;
   // the rest is a full random byte so every bit toggles.
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      case ($urandom_range(0, 8))
         0:       return 8'h00;
         1:       return 8'h01;
         2:       return 8'h02;
         3:       return 8'h03;
         4:       return 8'h13;
         5:       return 8'h84;
         6:       return 8'hC1;
         7:       return 8'hFE;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic req_payload_type random_instruction();
      req_payload_type ins;
      int unsigned     pick;
      pick       = $urandom_range(0, 99);
      ins.imm_lo = pick_byte();
      ins.imm_hi = pick_byte();
      if (pick < 35) begin
         ins.func = {OPG_MOVE, 6'($urandom)};
      end else if (pick < 55) begin
         ins.func = ld_imm(reg_code_type'($urandom_range(0, 7)));
      end else if (pick < 88) begin
         case ($urandom_range(0, 12))
            0:       ins.func = OP_LD_A_BC;
            1:       ins.func = OP_LD_A_DE;
            2:       ins.func = OP_LD_BC_A;
            3:       ins.func = OP_LD_DE_A;
            4:       ins.func = OP_LD_A_NN;
            5:       ins.func = OP_LDH_A_C;
            6:       ins.func = OP_LDH_C_A;
            7:       ins.func = OP_LDH_A_N;
            8:       ins.func = OP_LDH_N_A;
            9:       ins.func = OP_LD_A_HLI;
            10:      ins.func = OP_LD_HLI_A;
            11:      ins.func = OP_LD_A_HLD;
            default: ins.func = OP_LD_HLD_A;
         endcase
      end else begin
         ins.func = 8'($urandom);
      end
      return ins;
   endfunction

   // Present one instruction beat and hold it until the block takes it.
   task automatic send_item(input logic [7:0] func, input logic [7:0] lo, input logic [7:0] hi);
      req_chan.valid <= 1'b1;
      req_chan.data  <= '{func: func, imm_lo: lo, imm_hi: hi};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic idle_request(input int unsigned cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid and wait until every queued writeback has been seen.
   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   initial begin
      req_payload_type ins;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: walk every addressing form once from the power-on state.
      send_item(OP_LD_A_BC, 8'h00, 8'h00);               // read of cleared memory
      send_item(ld_imm(REG_MEM_HL), 8'hFF, 8'h00);       // LD (HL),n
      send_item(ld_move(REG_B, REG_MEM_HL), 8'h00, 8'h00);
      send_item(ld_move(REG_MEM_HL, REG_H), 8'h00, 8'h00);  // store H itself
      send_item(ld_move(REG_MEM_HL, REG_L), 8'h00, 8'h00);  // store L itself
      send_item(OP_HALT, 8'hFF, 8'hFF);
      send_item(OP_LD_NN_A, 8'h34, 8'h12);
      send_item(OP_NOP, 8'hFF, 8'hFF);
      send_item(OP_RST_38, 8'h00, 8'h00);
      send_item(ld_imm(REG_A), 8'hA5, 8'h00);
      send_item(OP_LDH_N_A, 8'hFF, 8'h00);               // top of the high page
      send_item(OP_LDH_A_N, 8'hFF, 8'hFF);
      send_item(ld_imm(REG_C), 8'h00, 8'hFF);
      send_item(OP_LDH_C_A, 8'h00, 8'h00);               // bottom of the high page
      send_item(OP_LDH_A_C, 8'h00, 8'h00);
      send_item(OP_LD_BC_A, 8'h00, 8'h00);
      send_item(OP_LD_DE_A, 8'h00, 8'h00);
      send_item(OP_LD_A_DE, 8'h00, 8'h00);
      send_item(OP_LD_A_NN, 8'h00, 8'hFF);               // nn little-endian: 0xFF00
      send_item(ld_imm(REG_H), 8'hFF, 8'h00);
      send_item(ld_imm(REG_L), 8'hFF, 8'h00);
      send_item(OP_LD_HLI_A, 8'h00, 8'h00);              // HL wraps up to 0x0000
      send_item(OP_LD_A_HLD, 8'h00, 8'h00);              // HL wraps down to 0xFFFF
      send_item(OP_LD_A_HLI, 8'h00, 8'h00);
      send_item(OP_LD_HLD_A, 8'h00, 8'h00);
      send_item(ld_move(REG_E, REG_D), 8'h00, 8'h00);
      directed_beats = 26;

      // Hold off until the directed beats have all come back.
      drain_pipeline();

      // Random part: bursty traffic in blocks of 100, a full drain now and
      // then, and a quiet tail with no idling on either side.
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 100 == 0)
            busy_level = (i >= RANDOM_BEATS - QUIET_TAIL) ? 0 : $urandom_range(0, 2);
         ins = random_instruction();
         if (i % 400 == 200)
            drain_pipeline();
         else if (busy_level != 0 && $urandom_range(0, 3) < busy_level)
            idle_request($urandom_range(1, 12));
         send_item(ins.func, ins.imm_lo, ins.imm_hi);
      end

      // Wait out the last writebacks, then keep watching for any stray beat.
      drain_pipeline();
      repeat (8) @(posedge clock);

      $display("Executed %0d directed and %0d random instructions: %0d stores, %0d unsupported",
               directed_beats, RANDOM_BEATS, shadow.stores, shadow.illegals);
      $display("Checked %0d response beats, %0d mismatches", shadow.checked, shadow.errors);
      if (shadow.errors == 0 && shadow.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+sv
sv/sm83li_pkg.sv
sv/sm83li_chan_if.sv
sv/sm83li_dmem.sv
sv/sm83_load_instruction_unit_top.sv
test/sm83_load_instruction_unit_top_test.sv
